// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

   localparam int MAX_PAYLOAD_DEF = 32;

   // Payload counter width, enough for a MAX_PAYLOAD of up to 63.
   localparam int CNT_W = 6;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE = 1'b1;

   localparam logic [7:0] HEAD_RESET   = 8'hFF;
   localparam logic [7:0] DEVICE_RESET = 8'hFC;
   localparam logic [7:0] MIN_LEN      = 8'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEAD,
      PH_LENGTH,
      PH_FUNC,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic {
      BK_IDLE,
      BK_SHOW
   } back_state_type;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic [7:0]       func;
   } frame_desc_type;

endpackage

// ===== rtl/sfp_req_if.sv =====
interface sfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sfp_rsp_if.sv =====
interface sfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] function_code;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic       last_of_frame;

   modport source (
      output valid, output function_code, output payload_byte,
      output byte_valid, output last_of_frame, input ready
   );
   modport sink (
      input valid, input function_code, input payload_byte,
      input byte_valid, input last_of_frame, output ready
   );
endinterface

// ===== rtl/serial_frame_parser_checksum.sv =====
// Frame parser for a received byte stream with an additive checksum.
// The req_ch channel takes one received byte per transaction. The parser hunts
// for the head and device bytes, then reads length, function, payload and
// checksum. A frame whose checksum matches leaves on rsp_ch as one transaction
// per payload byte, the final one marked last; an empty frame gives one
// transaction with byte_valid clear. A bad checksum drops the frame.
// The csr_ port writes the head byte (index 0) and device byte (index 1).
// Input bytes are taken one per cycle while req_ch.ready is high. Once a frame
// is queued, the output stage reads the RAM and offers the first result, then
// one result per cycle while rsp_ch is ready, passing through idle between
// frames. Payload sits in a two-bank RAM and a two-entry frame queue couples
// parser and output. When two good frames wait for output, req_ch.ready drops
// until the older frame is fully drained. A stall on rsp_ch only holds the
// current result. Reset returns the parser to hunting, restores head 0xFF and
// device 0xFC, and empties the queue; the payload RAM needs no clearing.
module serial_frame_parser_checksum
   import sfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   sfp_req_if.sink              req_ch,
   sfp_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int DEPTH = 2 * MAX_PAYLOAD;
   localparam int AW    = $clog2(DEPTH);

   frame_desc_type push_desc, head_desc;
   logic           q_push, q_pop, q_full, q_empty;
   logic           ram_wr_en, ram_rd_en;
   logic [AW-1:0]  ram_wr_addr, ram_rd_addr;
   logic [7:0]     ram_wr_data, ram_rd_data;

   sfp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_desc (push_desc),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   sfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .empty     (q_empty),
      .full      (q_full)
   );

   sfp_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sfp_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .desc        (head_desc),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== rtl/sfp_ram.sv =====
module sfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfp_front.sv =====
module sfp_front
   import sfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   localparam int AW = $clog2(2 * MAX_PAYLOAD)
) (
   input  logic                 clock,
   input  logic                 reset,
   sfp_req_if.sink              req_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output frame_desc_type       q_push_desc,
   output logic                 ram_wr_en,
   output logic [AW-1:0]        ram_wr_addr,
   output logic [7:0]           ram_wr_data
);

   localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 2);

   phase_type        phase_ff, phase_in;
   logic [7:0]       head_ff, device_ff;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       func_ff, func_in;
   logic [7:0]       sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             bank_ff, bank_in;
   logic             acc;
   logic [7:0]       b;
   logic [7:0]       need;
   logic             at_check;

   assign req_ch.ready = !q_full;
   assign acc          = req_ch.valid && !q_full;
   assign b            = req_ch.rx_byte;
   assign need         = len_ff - MIN_LEN;
   assign at_check     = (8'(count_ff) == need);

   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         case (phase_ff)
            PH_IDLE: begin
               if (b == head_ff) begin
                  phase_in = PH_HEAD;
               end
            end
            PH_HEAD: begin
               if (b == device_ff) begin
                  phase_in = PH_LENGTH;
               end else if (b != head_ff) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_LENGTH: begin
               if (b < MIN_LEN || b > LEN_MAX) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_FUNC;
               end
            end
            PH_FUNC: begin
               phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (at_check) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      len_in      = len_ff;
      func_in     = func_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      bank_in     = bank_ff;
      q_push      = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_data = b;
      if (bank_ff) begin
         ram_wr_addr = AW'(count_ff) + AW'(MAX_PAYLOAD);
      end else begin
         ram_wr_addr = AW'(count_ff);
      end
      q_push_desc.bank  = bank_ff;
      q_push_desc.count = count_ff;
      q_push_desc.func  = func_ff;
      if (acc) begin
         case (phase_ff)
            PH_LENGTH: begin
               len_in = b;
               sum_in = b;
            end
            PH_FUNC: begin
               func_in  = b;
               sum_in   = sum_ff + b;
               count_in = '0;
            end
            PH_PAYLOAD: begin
               if (at_check) begin
                  if (sum_ff == b) begin
                     q_push  = 1'b1;
                     bank_in = !bank_ff;
                  end
               end else begin
                  ram_wr_en = 1'b1;
                  sum_in    = sum_ff + b;
                  count_in  = count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         head_ff   <= HEAD_RESET;
         device_ff <= DEVICE_RESET;
         len_ff    <= '0;
         func_ff   <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         bank_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         func_ff  <= func_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         bank_ff  <= bank_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HEAD:   head_ff   <= csr_wdata;
               CSR_DEVICE: device_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ===== rtl/sfp_queue.sv =====
module sfp_queue
   import sfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   input  logic           pop,
   output frame_desc_type head_desc,
   output logic           empty,
   output logic           full
);

   frame_desc_type ent_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     fill_ff;

   assign empty     = (fill_ff == 2'd0);
   assign full      = (fill_ff == 2'd2);
   assign head_desc = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

// ===== rtl/sfp_back.sv =====
module sfp_back
   import sfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   localparam int AW = $clog2(2 * MAX_PAYLOAD)
) (
   input  logic           clock,
   input  logic           reset,
   input  frame_desc_type desc,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           ram_rd_en,
   output logic [AW-1:0]  ram_rd_addr,
   input  logic [7:0]     ram_rd_data,
   sfp_rsp_if.source      rsp_ch
);

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] idx_next;
   logic [CNT_W-1:0] rd_idx;
   logic             has_data;
   logic             is_last;
   logic             taken;

   assign idx_next = idx_ff + 1'b1;
   assign has_data = (desc.count != '0);
   assign is_last  = !has_data || (idx_next == desc.count);
   assign taken    = (state_ff == BK_SHOW) && rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = BK_SHOW;
            end
         end
         BK_SHOW: begin
            if (rsp_ch.ready && is_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      rd_idx    = '0;
      ram_rd_en = 1'b0;
      q_pop     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               ram_rd_en = 1'b1;
               idx_in    = '0;
            end
         end
         BK_SHOW: begin
            if (taken) begin
               if (is_last) begin
                  q_pop = 1'b1;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_idx    = idx_next;
                  idx_in    = idx_next;
               end
            end
         end
         default: begin
         end
      endcase
      if (desc.bank) begin
         ram_rd_addr = AW'(rd_idx) + AW'(MAX_PAYLOAD);
      end else begin
         ram_rd_addr = AW'(rd_idx);
      end
   end

   assign rsp_ch.valid         = (state_ff == BK_SHOW);
   assign rsp_ch.function_code = desc.func;
   assign rsp_ch.payload_byte  = has_data ? ram_rd_data : 8'd0;
   assign rsp_ch.byte_valid    = has_data;
   assign rsp_ch.last_of_frame = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
